// ===== design/otic_pkg.sv =====
`timescale 1ns / 1ps

package otic_pkg;

   localparam int POS_W   = 32;
   localparam int VAR_W   = 16;
   localparam int SGN_W   = 2;
   localparam int FIELD_W = POS_W + 2 * SGN_W + 2 * VAR_W;
   localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;
   localparam int PAD_W   = TDATA_W - FIELD_W;

   typedef enum logic [SGN_W-1:0] {
      SGN_NEG  = 2'd0,
      SGN_ZERO = 2'd1,
      SGN_POS  = 2'd2,
      SGN_NONE = 2'd3
   } sign_type;

   typedef enum logic {
      CMD_ENCODE = 1'b0,
      CMD_DECODE = 1'b1
   } command_type;

   typedef struct packed {
      command_type cmd;
      logic        bad;
      logic        zero;
      sign_type    sign_hi;
      sign_type    sign_lo;
   } ctrl_type;

endpackage

// ===== design/otic_prep.sv =====
`timescale 1ns / 1ps

module otic_prep #(
   parameter int INDEX_BITS = 32,
   parameter int VAR_BITS = 16,
   localparam int SQ_STEPS = INDEX_BITS / 2,
   localparam int MW = (VAR_BITS > SQ_STEPS) ? VAR_BITS : SQ_STEPS,
   localparam int NW = 2 * SQ_STEPS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            up_valid,
   output logic                            up_ready,
   input  logic                            up_cmd,
   input  logic [otic_pkg::POS_W-1:0]      up_position,
   input  logic [otic_pkg::SGN_W-1:0]      up_sign_a,
   input  logic [otic_pkg::VAR_W-1:0]      up_var_a,
   input  logic [otic_pkg::SGN_W-1:0]      up_sign_b,
   input  logic [otic_pkg::VAR_W-1:0]      up_var_b,
   output logic                            dn_valid,
   input  logic                            dn_ready,
   output otic_pkg::ctrl_type              dn_ctrl,
   output logic [INDEX_BITS-1:0]           dn_pos,
   output logic [VAR_BITS-1:0]             dn_vhi,
   output logic [VAR_BITS-1:0]             dn_vlo,
   output logic [MW-1:0]                   dn_root,
   output logic [NW-1:0]                   dn_rad
);

   logic                  valid_ff, valid_in;
   otic_pkg::ctrl_type    ctrl_ff, ctrl_in, ctrl_new;
   logic [INDEX_BITS-1:0] pos_ff, pos_in, pos_new;
   logic [VAR_BITS-1:0]   vhi_ff, vhi_in, vlo_ff, vlo_in;
   logic [MW-1:0]         root_ff, root_in;
   logic [NW-1:0]         rad_ff, rad_in;

   logic [VAR_BITS-1:0]   va, vb, vhi_new, vlo_new;
   otic_pkg::sign_type    shi, slo;
   logic                  swap, enc_bad, load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      va      = VAR_BITS'(up_var_a);
      vb      = VAR_BITS'(up_var_b);
      swap    = va < vb;
      shi     = otic_pkg::sign_type'(swap ? up_sign_b : up_sign_a);
      slo     = otic_pkg::sign_type'(swap ? up_sign_a : up_sign_b);
      vhi_new = swap ? vb : va;
      vlo_new = swap ? va : vb;
      pos_new = INDEX_BITS'(up_position);
      enc_bad = (shi == otic_pkg::SGN_NONE) || (slo == otic_pkg::SGN_NONE) ||
                ((shi != otic_pkg::SGN_ZERO) &&
                 ((va == vb) || ((slo != otic_pkg::SGN_ZERO) && (vlo_new == '0))));
      ctrl_new.cmd     = otic_pkg::command_type'(up_cmd);
      ctrl_new.sign_hi = shi;
      ctrl_new.sign_lo = slo;
      if (ctrl_new.cmd == otic_pkg::CMD_DECODE) begin
         ctrl_new.bad  = 1'b0;
         ctrl_new.zero = (pos_new == '0);
      end else begin
         ctrl_new.bad  = enc_bad;
         ctrl_new.zero = enc_bad || (shi == otic_pkg::SGN_ZERO);
      end
   end

   always_comb begin
      valid_in = up_ready ? up_valid : valid_ff;
      ctrl_in  = ctrl_ff;
      pos_in   = pos_ff;
      vhi_in   = vhi_ff;
      vlo_in   = vlo_ff;
      root_in  = root_ff;
      rad_in   = rad_ff;
      if (load) begin
         ctrl_in = ctrl_new;
         pos_in  = pos_new;
         vhi_in  = vhi_new;
         vlo_in  = vlo_new;
         rad_in  = NW'((pos_new - INDEX_BITS'(1)) >> 1);
         if (ctrl_new.cmd == otic_pkg::CMD_DECODE) begin
            root_in = '0;
         end else begin
            root_in = MW'(vhi_new) - MW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff <= ctrl_in;
      pos_ff  <= pos_in;
      vhi_ff  <= vhi_in;
      vlo_ff  <= vlo_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
   end

   assign dn_valid = valid_ff;
   assign dn_ctrl  = ctrl_ff;
   assign dn_pos   = pos_ff;
   assign dn_vhi   = vhi_ff;
   assign dn_vlo   = vlo_ff;
   assign dn_root  = root_ff;
   assign dn_rad   = rad_ff;

endmodule

// ===== design/otic_cell.sv =====
`timescale 1ns / 1ps

module otic_cell #(
   parameter int INDEX_BITS = 32,
   parameter int VAR_BITS = 16,
   localparam int SQ_STEPS = INDEX_BITS / 2,
   localparam int MW = (VAR_BITS > SQ_STEPS) ? VAR_BITS : SQ_STEPS,
   localparam int NW = 2 * SQ_STEPS,
   localparam int RW = SQ_STEPS + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  otic_pkg::ctrl_type    up_ctrl,
   input  logic [INDEX_BITS-1:0] up_pos,
   input  logic [VAR_BITS-1:0]   up_vhi,
   input  logic [VAR_BITS-1:0]   up_vlo,
   input  logic [MW-1:0]         up_root,
   input  logic [RW-1:0]         up_rem,
   input  logic [NW-1:0]         up_rad,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output otic_pkg::ctrl_type    dn_ctrl,
   output logic [INDEX_BITS-1:0] dn_pos,
   output logic [VAR_BITS-1:0]   dn_vhi,
   output logic [VAR_BITS-1:0]   dn_vlo,
   output logic [MW-1:0]         dn_root,
   output logic [RW-1:0]         dn_rem,
   output logic [NW-1:0]         dn_rad
);

   logic                  valid_ff, valid_in;
   otic_pkg::ctrl_type    ctrl_ff, ctrl_in;
   logic [INDEX_BITS-1:0] pos_ff, pos_in;
   logic [VAR_BITS-1:0]   vhi_ff, vhi_in, vlo_ff, vlo_in;
   logic [MW-1:0]         root_ff, root_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [NW-1:0]         rad_ff, rad_in;

   logic [RW-1:0]         rem_sh, trial;
   logic                  ge, load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   // one root bit per cell: bring down the next bit pair and try (root << 2) | 1
   always_comb begin
      rem_sh = {up_rem[RW-3:0], up_rad[NW-1 -: 2]};
      trial  = RW'({up_root, 2'b01});
      ge     = rem_sh >= trial;
   end

   always_comb begin
      valid_in = up_ready ? up_valid : valid_ff;
      ctrl_in  = ctrl_ff;
      pos_in   = pos_ff;
      vhi_in   = vhi_ff;
      vlo_in   = vlo_ff;
      root_in  = root_ff;
      rem_in   = rem_ff;
      rad_in   = rad_ff;
      if (load) begin
         ctrl_in = up_ctrl;
         pos_in  = up_pos;
         vhi_in  = up_vhi;
         vlo_in  = up_vlo;
         root_in = up_root;
         rem_in  = up_rem;
         rad_in  = up_rad;
         if (up_ctrl.cmd == otic_pkg::CMD_DECODE) begin
            root_in = {up_root[MW-2:0], ge};
            rem_in  = ge ? (rem_sh - trial) : rem_sh;
            rad_in  = {up_rad[NW-3:0], 2'b00};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ctrl_ff <= ctrl_in;
      pos_ff  <= pos_in;
      vhi_ff  <= vhi_in;
      vlo_ff  <= vlo_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
      rad_ff  <= rad_in;
   end

   assign dn_valid = valid_ff;
   assign dn_ctrl  = ctrl_ff;
   assign dn_pos   = pos_ff;
   assign dn_vhi   = vhi_ff;
   assign dn_vlo   = vlo_ff;
   assign dn_root  = root_ff;
   assign dn_rem   = rem_ff;
   assign dn_rad   = rad_ff;

endmodule

// ===== design/otic_finish.sv =====
`timescale 1ns / 1ps

module otic_finish #(
   parameter int INDEX_BITS = 32,
   parameter int VAR_BITS = 16,
   localparam int SQ_STEPS = INDEX_BITS / 2,
   localparam int MW = (VAR_BITS > SQ_STEPS) ? VAR_BITS : SQ_STEPS,
   localparam int ACC_W = 2 * MW + 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_ready,
   input  otic_pkg::ctrl_type    up_ctrl,
   input  logic [INDEX_BITS-1:0] up_pos,
   input  logic [VAR_BITS-1:0]   up_vhi,
   input  logic [VAR_BITS-1:0]   up_vlo,
   input  logic [MW-1:0]         up_root,
   output logic                  dn_valid,
   input  logic                  dn_ready,
   output logic [INDEX_BITS-1:0] dn_pos,
   output otic_pkg::sign_type    dn_sign_hi,
   output logic [VAR_BITS-1:0]   dn_vhi,
   output otic_pkg::sign_type    dn_sign_lo,
   output logic [VAR_BITS-1:0]   dn_vlo,
   output logic                  dn_bad
);

   localparam logic [ACC_W-1:0] IMASK = ACC_W'({INDEX_BITS{1'b1}});

   // stage 1: square of m
   logic                  v1_ff, v1_in;
   otic_pkg::ctrl_type    c1_ff, c1_in;
   logic [INDEX_BITS-1:0] p1_ff, p1_in;
   logic [VAR_BITS-1:0]   vh1_ff, vh1_in, vl1_ff, vl1_in;
   logic [MW-1:0]         m1_ff, m1_in;
   logic [2*MW-1:0]       sq1_ff, sq1_in;

   // stage 2: group base and hi offset
   logic                  v2_ff, v2_in;
   otic_pkg::ctrl_type    c2_ff, c2_in;
   logic [INDEX_BITS-1:0] p2_ff, p2_in;
   logic [VAR_BITS-1:0]   vh2_ff, vh2_in, vl2_ff, vl2_in;
   logic [MW-1:0]         m2_ff, m2_in;
   logic [ACC_W-1:0]      acc2_ff, acc2_in;
   logic                  sqovf2_ff, sqovf2_in;

   // stage 3: result register
   logic                  v3_ff, v3_in;
   otic_pkg::command_type cmd3_ff, cmd3_in;
   logic [INDEX_BITS-1:0] p3_ff, p3_in;
   otic_pkg::sign_type    shi3_ff, shi3_in, slo3_ff, slo3_in;
   logic [VAR_BITS-1:0]   vh3_ff, vh3_in, vl3_ff, vl3_in;
   logic                  bad3_ff, bad3_in;

   logic r1, r2, r3, ld1, ld2, ld3;
   logic [ACC_W-1:0] base2, half3, sep3, lo_add3, total3;
   logic [MW:0]      vhi_full3;
   logic             neg3, zero_lo3, ovf3;

   assign r3       = !v3_ff || dn_ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign up_ready = r1;
   assign ld1      = up_valid && r1;
   assign ld2      = v1_ff && r2;
   assign ld3      = v2_ff && r3;

   always_comb begin
      v1_in  = r1 ? up_valid : v1_ff;
      c1_in  = ld1 ? up_ctrl : c1_ff;
      p1_in  = ld1 ? up_pos : p1_ff;
      vh1_in = ld1 ? up_vhi : vh1_ff;
      vl1_in = ld1 ? up_vlo : vl1_ff;
      m1_in  = ld1 ? up_root : m1_ff;
      sq1_in = ld1 ? (2*MW)'(up_root * up_root) : sq1_ff;
   end

   always_comb begin
      base2     = (ACC_W'(sq1_ff) << 1) + ACC_W'(1);
      v2_in     = r2 ? v1_ff : v2_ff;
      c2_in     = ld2 ? c1_ff : c2_ff;
      p2_in     = ld2 ? p1_ff : p2_ff;
      vh2_in    = ld2 ? vh1_ff : vh2_ff;
      vl2_in    = ld2 ? vl1_ff : vl2_ff;
      m2_in     = ld2 ? m1_ff : m2_ff;
      sqovf2_in = ld2 ? (ACC_W'(sq1_ff) > (IMASK >> 1)) : sqovf2_ff;
      acc2_in   = acc2_ff;
      if (ld2) begin
         if (c1_ff.cmd == otic_pkg::CMD_DECODE) begin
            acc2_in = ACC_W'(p1_ff) - base2;
         end else if (c1_ff.sign_hi == otic_pkg::SGN_POS) begin
            acc2_in = base2 + ACC_W'({m1_ff, 1'b1});
         end else begin
            acc2_in = base2;
         end
      end
   end

   always_comb begin
      half3     = ACC_W'({m2_ff, 1'b0});
      neg3      = acc2_ff <= half3;
      sep3      = neg3 ? acc2_ff : (acc2_ff - half3 - ACC_W'(1));
      zero_lo3  = sep3 == '0;
      vhi_full3 = {1'b0, m2_ff} + (MW+1)'(1);
      case (c2_ff.sign_lo)
         otic_pkg::SGN_POS: lo_add3 = ACC_W'({vl2_ff, 1'b0});
         otic_pkg::SGN_NEG: lo_add3 = ACC_W'({vl2_ff, 1'b0}) - ACC_W'(1);
         default:           lo_add3 = '0;
      endcase
      total3 = acc2_ff + lo_add3;
      ovf3   = sqovf2_ff || (total3 > IMASK);
   end

   always_comb begin
      v3_in   = r3 ? v2_ff : v3_ff;
      cmd3_in = cmd3_ff;
      p3_in   = p3_ff;
      shi3_in = shi3_ff;
      slo3_in = slo3_ff;
      vh3_in  = vh3_ff;
      vl3_in  = vl3_ff;
      bad3_in = bad3_ff;
      if (ld3) begin
         cmd3_in = c2_ff.cmd;
         if (c2_ff.cmd == otic_pkg::CMD_DECODE) begin
            p3_in = p2_ff;
            if (c2_ff.zero) begin
               shi3_in = otic_pkg::SGN_ZERO;
               slo3_in = otic_pkg::SGN_ZERO;
               vh3_in  = '0;
               vl3_in  = '0;
               bad3_in = 1'b0;
            end else begin
               shi3_in = neg3 ? otic_pkg::SGN_NEG : otic_pkg::SGN_POS;
               if (zero_lo3) begin
                  slo3_in = otic_pkg::SGN_ZERO;
                  vl3_in  = '0;
               end else begin
                  slo3_in = sep3[0] ? otic_pkg::SGN_NEG : otic_pkg::SGN_POS;
                  vl3_in  = VAR_BITS'((sep3 + ACC_W'(1)) >> 1);
               end
               vh3_in  = VAR_BITS'(vhi_full3);
               bad3_in = |(vhi_full3 >> VAR_BITS);
            end
         end else begin
            shi3_in = c2_ff.sign_hi;
            slo3_in = c2_ff.sign_lo;
            vh3_in  = vh2_ff;
            vl3_in  = vl2_ff;
            if (c2_ff.zero) begin
               p3_in   = '0;
               bad3_in = c2_ff.bad;
            end else begin
               p3_in   = ovf3 ? '0 : INDEX_BITS'(total3);
               bad3_in = ovf3;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      c1_ff     <= c1_in;
      p1_ff     <= p1_in;
      vh1_ff    <= vh1_in;
      vl1_ff    <= vl1_in;
      m1_ff     <= m1_in;
      sq1_ff    <= sq1_in;
      c2_ff     <= c2_in;
      p2_ff     <= p2_in;
      vh2_ff    <= vh2_in;
      vl2_ff    <= vl2_in;
      m2_ff     <= m2_in;
      acc2_ff   <= acc2_in;
      sqovf2_ff <= sqovf2_in;
      cmd3_ff   <= cmd3_in;
      p3_ff     <= p3_in;
      shi3_ff   <= shi3_in;
      slo3_ff   <= slo3_in;
      vh3_ff    <= vh3_in;
      vl3_ff    <= vl3_in;
      bad3_ff   <= bad3_in;
   end

   assign dn_valid   = v3_ff;
   assign dn_pos     = p3_ff;
   assign dn_sign_hi = shi3_ff;
   assign dn_vhi     = vh3_ff;
   assign dn_sign_lo = slo3_ff;
   assign dn_vlo     = vl3_ff;
   assign dn_bad     = bad3_ff;

`ifndef SYNTHESIS
   a_enc_bad_zero_pos: assert property (@(posedge clock) disable iff (reset)
      v3_ff && (cmd3_ff == otic_pkg::CMD_ENCODE) && bad3_ff |-> (p3_ff == '0))
      else $error("encode result flagged invalid with nonzero index");

   a_dec_zero_term: assert property (@(posedge clock) disable iff (reset)
      v3_ff && (cmd3_ff == otic_pkg::CMD_DECODE) && (p3_ff == '0) |->
      (shi3_ff == otic_pkg::SGN_ZERO) && (slo3_ff == otic_pkg::SGN_ZERO) &&
      (vh3_ff == '0) && (vl3_ff == '0) && !bad3_ff)
      else $error("index zero did not decode to the zero term");

   a_dec_hi_sign: assert property (@(posedge clock) disable iff (reset)
      v3_ff && (cmd3_ff == otic_pkg::CMD_DECODE) && (p3_ff != '0) |->
      (shi3_ff == otic_pkg::SGN_NEG) || (shi3_ff == otic_pkg::SGN_POS))
      else $error("nonzero index decoded with zero hi sign");

   a_valid_signs: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !bad3_ff |->
      (shi3_ff != otic_pkg::SGN_NONE) && (slo3_ff != otic_pkg::SGN_NONE))
      else $error("valid result carries a non-sign code");
`endif

endmodule

// ===== design/octagon_term_index_codec.sv =====
`timescale 1ns / 1ps

// channel | direction | tdata (low bit up)                               | tuser
// req     | in        | position_in, sign_a, var_a, sign_b, var_b, pad  | command
// rsp     | out       | position_out, sign_hi, var_hi, sign_lo, var_lo  | invalid
//
// one transfer per cycle sustained in both directions while rsp_tready stays high, any mix of encode and decode
// each item passes an entry register, one square-root cell per root bit,
// then square, base and result registers
// reset clears only the stage valid flags
// with rsp_tready low the result holds; empty stages upstream keep filling and
// req_tready falls only when every stage holds an item

module octagon_term_index_codec #(
   parameter int INDEX_BITS = 32,
   parameter int VAR_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // position_in[31:0], sign_a[33:32], var_a[49:34], sign_b[51:50], var_b[67:52]
   input  logic [otic_pkg::TDATA_W-1:0]  req_tdata,
   // command[0]
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // position_out[31:0], sign_hi[33:32], var_hi[49:34], sign_lo[51:50], var_lo[67:52]
   output logic [otic_pkg::TDATA_W-1:0]  rsp_tdata,
   // invalid[0]
   output logic                          rsp_tuser
);

   localparam int SQ_STEPS = INDEX_BITS / 2;
   localparam int MW = (VAR_BITS > SQ_STEPS) ? VAR_BITS : SQ_STEPS;
   localparam int NW = 2 * SQ_STEPS;
   localparam int RW = SQ_STEPS + 2;
   localparam int P0 = otic_pkg::POS_W;
   localparam int P1 = P0 + otic_pkg::SGN_W;
   localparam int P2 = P1 + otic_pkg::VAR_W;
   localparam int P3 = P2 + otic_pkg::SGN_W;

   logic                  vld  [SQ_STEPS+1];
   logic                  rdy  [SQ_STEPS+1];
   otic_pkg::ctrl_type    ctl  [SQ_STEPS+1];
   logic [INDEX_BITS-1:0] pos  [SQ_STEPS+1];
   logic [VAR_BITS-1:0]   vhi  [SQ_STEPS+1];
   logic [VAR_BITS-1:0]   vlo  [SQ_STEPS+1];
   logic [MW-1:0]         root [SQ_STEPS+1];
   logic [RW-1:0]         rem  [SQ_STEPS+1];
   logic [NW-1:0]         rad  [SQ_STEPS+1];

   logic [INDEX_BITS-1:0] out_pos;
   otic_pkg::sign_type    out_shi, out_slo;
   logic [VAR_BITS-1:0]   out_vhi, out_vlo;
   logic                  out_bad;

   otic_prep #(.INDEX_BITS(INDEX_BITS), .VAR_BITS(VAR_BITS)) u_prep (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (req_tvalid),
      .up_ready    (req_tready),
      .up_cmd      (req_tuser),
      .up_position (req_tdata[P0-1:0]),
      .up_sign_a   (req_tdata[P1-1:P0]),
      .up_var_a    (req_tdata[P2-1:P1]),
      .up_sign_b   (req_tdata[P3-1:P2]),
      .up_var_b    (req_tdata[otic_pkg::FIELD_W-1:P3]),
      .dn_valid    (vld[0]),
      .dn_ready    (rdy[0]),
      .dn_ctrl     (ctl[0]),
      .dn_pos      (pos[0]),
      .dn_vhi      (vhi[0]),
      .dn_vlo      (vlo[0]),
      .dn_root     (root[0]),
      .dn_rad      (rad[0])
   );

   assign rem[0] = '0;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_cell
      otic_cell #(.INDEX_BITS(INDEX_BITS), .VAR_BITS(VAR_BITS)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (vld[k]),
         .up_ready (rdy[k]),
         .up_ctrl  (ctl[k]),
         .up_pos   (pos[k]),
         .up_vhi   (vhi[k]),
         .up_vlo   (vlo[k]),
         .up_root  (root[k]),
         .up_rem   (rem[k]),
         .up_rad   (rad[k]),
         .dn_valid (vld[k+1]),
         .dn_ready (rdy[k+1]),
         .dn_ctrl  (ctl[k+1]),
         .dn_pos   (pos[k+1]),
         .dn_vhi   (vhi[k+1]),
         .dn_vlo   (vlo[k+1]),
         .dn_root  (root[k+1]),
         .dn_rem   (rem[k+1]),
         .dn_rad   (rad[k+1])
      );
   end

   otic_finish #(.INDEX_BITS(INDEX_BITS), .VAR_BITS(VAR_BITS)) u_finish (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (vld[SQ_STEPS]),
      .up_ready   (rdy[SQ_STEPS]),
      .up_ctrl    (ctl[SQ_STEPS]),
      .up_pos     (pos[SQ_STEPS]),
      .up_vhi     (vhi[SQ_STEPS]),
      .up_vlo     (vlo[SQ_STEPS]),
      .up_root    (root[SQ_STEPS]),
      .dn_valid   (rsp_tvalid),
      .dn_ready   (rsp_tready),
      .dn_pos     (out_pos),
      .dn_sign_hi (out_shi),
      .dn_vhi     (out_vhi),
      .dn_sign_lo (out_slo),
      .dn_vlo     (out_vlo),
      .dn_bad     (out_bad)
   );

   assign rsp_tdata = {{otic_pkg::PAD_W{1'b0}},
                       otic_pkg::VAR_W'(out_vlo),
                       out_slo,
                       otic_pkg::VAR_W'(out_vhi),
                       out_shi,
                       otic_pkg::POS_W'(out_pos)};
   assign rsp_tuser = out_bad;

endmodule
